// File: rtl/core/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every edge where ant is true.
`define ASSERT_IMPLY(lbl, clk, rstn, ant, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |-> (prop)) \
    else $error("immediate implication failed");

// Check that prop holds at the next edge after one where ant is true.
`define ASSERT_NEXT(lbl, clk, rstn, ant, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |=> (prop)) \
    else $error("next-cycle implication failed");

`endif

// File: rtl/core/mcgn_pkg.sv
// Types, codes, constants and helper functions of the month calendar grid navigator.
package mcgn_pkg;

    localparam int NUM_CELLS   = 42;
    localparam int NUM_COLS    = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    typedef enum logic [2:0] {
        OP_LOAD       = 3'd0,
        OP_PREV_MONTH = 3'd1,
        OP_NEXT_MONTH = 3'd2,
        OP_PREV_YEAR  = 3'd3,
        OP_NEXT_YEAR  = 3'd4,
        OP_HOME       = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        CFG_COL0_WEEKDAY    = 2'd0,
        CFG_HIGHLIGHT_DAY   = 2'd1,
        CFG_HIGHLIGHT_MONTH = 2'd2,
        CFG_HIGHLIGHT_YEAR  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]  col0_weekday;
        logic [4:0]  highlight_day;
        logic [3:0]  highlight_month;
        logic [13:0] highlight_year;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  month;
        logic [13:0] year;
    } view_t;

    // Everything the emitter needs to send one grid
    typedef struct packed {
        logic [2:0]  offset;
        logic [4:0]  ndays;
        logic [4:0]  hl_day;   // 0 when the highlight date is not on view
        logic [3:0]  month;
        logic [13:0] year;
    } grid_t;

    // (13 * (m + 1)) / 5 for the shifted month 3..14
    function automatic logic [5:0] month_term(input logic [3:0] m);
        logic [5:0] t;
        unique case (m)
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            4'd13:   t = 6'd36;
            4'd14:   t = 6'd39;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

    // Fold octal digits, since 8 is 1 modulo 7
    function automatic logic [2:0] mod7(input logic [10:0] x);
        logic [4:0] s1;
        logic [3:0] s2;
        s1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[10:9]);
        s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
        if (s2 >= 4'd7)
        begin
            s2 = s2 - 4'd7;
        end
        return s2[2:0];
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        unique case (m)
            4'd2:                      n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

// File: rtl/core/mcgn_front.sv
// Front end: accept navigation events, update the view, queue the months to draw.
module mcgn_front #(
    parameter int YEAR_LIMIT = 9999
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [2:0]          operation,
    input  logic [3:0]          load_month,
    input  logic [13:0]         load_year,
    input  mcgn_pkg::cfg_t      cfg,
    input  logic                q_full,
    output logic                q_write,
    output mcgn_pkg::view_t     q_data
);

    localparam logic [14:0] LIMIT = 15'(YEAR_LIMIT);

    logic [3:0]  view_month_reg, view_month_next;
    logic [13:0] view_year_reg, view_year_next;
    logic        valid;

    always_comb
    begin
        valid           = 1'b0;
        view_month_next = view_month_reg;
        view_year_next  = view_year_reg;
        unique case (operation)
            mcgn_pkg::OP_LOAD:
            begin
                if (load_month >= 4'd1 && load_month <= 4'd12 &&
                    load_year != 14'd0 && {1'b0, load_year} <= LIMIT)
                begin
                    valid           = 1'b1;
                    view_month_next = load_month;
                    view_year_next  = load_year;
                end
            end
            mcgn_pkg::OP_PREV_MONTH:
            begin
                if (!(view_year_reg <= 14'd1 &&
                      (view_year_reg == 14'd0 || view_month_reg == 4'd1)))
                begin
                    valid = 1'b1;
                    if (view_month_reg == 4'd1)
                    begin
                        view_month_next = 4'd12;
                        view_year_next  = view_year_reg - 14'd1;
                    end
                    else
                    begin
                        view_month_next = view_month_reg - 4'd1;
                    end
                end
            end
            mcgn_pkg::OP_NEXT_MONTH:
            begin
                if (!({1'b0, view_year_reg} > LIMIT ||
                      ({1'b0, view_year_reg} == LIMIT && view_month_reg == 4'd12)))
                begin
                    valid = 1'b1;
                    if (view_month_reg == 4'd12)
                    begin
                        view_month_next = 4'd1;
                        view_year_next  = view_year_reg + 14'd1;
                    end
                    else
                    begin
                        view_month_next = view_month_reg + 4'd1;
                    end
                end
            end
            mcgn_pkg::OP_PREV_YEAR:
            begin
                if (view_year_reg > 14'd1)
                begin
                    valid          = 1'b1;
                    view_year_next = view_year_reg - 14'd1;
                end
            end
            mcgn_pkg::OP_NEXT_YEAR:
            begin
                if ({1'b0, view_year_reg} < LIMIT)
                begin
                    valid          = 1'b1;
                    view_year_next = view_year_reg + 14'd1;
                end
            end
            mcgn_pkg::OP_HOME:
            begin
                if (cfg.highlight_month >= 4'd1 && cfg.highlight_month <= 4'd12 &&
                    cfg.highlight_year != 14'd0 && {1'b0, cfg.highlight_year} <= LIMIT)
                begin
                    valid           = 1'b1;
                    view_month_next = cfg.highlight_month;
                    view_year_next  = cfg.highlight_year;
                end
            end
            default:
            begin
                valid = 1'b0;
            end
        endcase
    end

    // Refused and unknown events are taken and dropped
    assign q_write      = push && !q_full && valid;
    assign q_data.month = view_month_next;
    assign q_data.year  = view_year_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_month_reg <= 4'd1;
            view_year_reg  <= 14'd2016;
        end
        else if (q_write)
        begin
            view_month_reg <= view_month_next;
            view_year_reg  <= view_year_next;
        end
    end

endmodule

// File: rtl/core/mcgn_queue.sv
// Short queue of months waiting to be drawn, between the front and back ends.
module mcgn_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  mcgn_pkg::view_t     wr_data,
    input  logic                rd_en,
    output mcgn_pkg::view_t     rd_data,
    output logic                q_empty,
    output logic                q_full
);

    mcgn_pkg::view_t               mem_reg [mcgn_pkg::QUEUE_DEPTH];
    logic [mcgn_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [mcgn_pkg::QCNT_W-1:0]   count_reg;

    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == mcgn_pkg::QCNT_W'(mcgn_pkg::QUEUE_DEPTH));
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!wr_en && rd_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/mcgn_prep.sv
// Back end, first part: work out first weekday, month length and highlight of a month.
module mcgn_prep (
    input  logic                clk,
    input  logic                rst_n,
    input  mcgn_pkg::cfg_t      cfg,
    input  logic                q_empty,
    input  mcgn_pkg::view_t     q_data,
    output logic                q_pop,
    output logic                grid_valid,
    output mcgn_pkg::grid_t     grid,
    input  logic                grid_take
);

    typedef enum logic [6:0] {
        P_IDLE = 7'b0000001,
        P_MUL  = 7'b0000010,
        P_DIG1 = 7'b0000100,
        P_DIG2 = 7'b0001000,
        P_SUM  = 7'b0010000,
        P_FIN  = 7'b0100000,
        P_HOLD = 7'b1000000
    } pstate_t;

    pstate_t         state_reg, state_next;
    logic [3:0]      m_reg, madj_reg;
    logic [13:0]     y_reg, yadj_reg;
    logic [26:0]     prod_reg;
    logic [7:0]      c_reg, c2_reg;
    logic [6:0]      k_reg;
    logic [10:0]     sum_reg;
    logic            leap_reg;
    mcgn_pkg::grid_t grid_reg;

    logic [13:0]     c_x100, c2_x100, k2;
    logic [2:0]      fw, ws;
    logic [3:0]      off_wide;

    assign q_pop      = (state_reg == P_IDLE) && !q_empty;
    assign grid_valid = (state_reg == P_HOLD);
    assign grid       = grid_reg;

    assign c_x100  = 14'(c_reg)  * 14'd100;
    assign c2_x100 = 14'(c2_reg) * 14'd100;
    assign k2      = y_reg - c2_x100;
    assign fw      = mcgn_pkg::mod7(sum_reg);
    assign ws      = (cfg.col0_weekday == 3'd7) ? 3'd0 : cfg.col0_weekday;
    assign off_wide = (fw >= ws) ? 4'(fw - ws) : (4'(fw) + 4'd7 - 4'(ws));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            P_IDLE: if (!q_empty) state_next = P_MUL;
            P_MUL:  state_next = P_DIG1;
            P_DIG1: state_next = P_DIG2;
            P_DIG2: state_next = P_SUM;
            P_SUM:  state_next = P_FIN;
            P_FIN:  state_next = P_HOLD;
            P_HOLD: if (grid_take) state_next = P_IDLE;
            default: state_next = P_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath: each reciprocal product is registered in prod_reg before use
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            P_IDLE:
            begin
                m_reg <= q_data.month;
                y_reg <= q_data.year;
                if (q_data.month < 4'd3)
                begin
                    madj_reg <= q_data.month + 4'd12;
                    yadj_reg <= q_data.year - 14'd1;
                end
                else
                begin
                    madj_reg <= q_data.month;
                    yadj_reg <= q_data.year;
                end
            end
            P_MUL:
            begin
                prod_reg <= 27'(yadj_reg) * 27'(mcgn_pkg::RECIP_100);
            end
            P_DIG1:
            begin
                c_reg    <= prod_reg[mcgn_pkg::RECIP_SHIFT +: 8];
                prod_reg <= 27'(y_reg) * 27'(mcgn_pkg::RECIP_100);
            end
            P_DIG2:
            begin
                k_reg  <= 7'(yadj_reg - c_x100);
                c2_reg <= prod_reg[mcgn_pkg::RECIP_SHIFT +: 8];
            end
            P_SUM:
            begin
                sum_reg <= 11'(mcgn_pkg::month_term(madj_reg)) + 11'(c_reg[7:2])
                         + 11'(c_reg) * 11'd5 + 11'(k_reg) + 11'(k_reg[6:2]);
                leap_reg <= (k2 != 14'd0) ? (y_reg[1:0] == 2'd0) : (c2_reg[1:0] == 2'd0);
            end
            P_FIN:
            begin
                grid_reg.offset <= off_wide[2:0];
                grid_reg.ndays  <= mcgn_pkg::days_in(m_reg, leap_reg);
                grid_reg.hl_day <= (m_reg == cfg.highlight_month &&
                                    y_reg == cfg.highlight_year) ? cfg.highlight_day : 5'd0;
                grid_reg.month  <= m_reg;
                grid_reg.year   <= y_reg;
            end
            P_HOLD:
            begin
                grid_reg <= grid_reg;
            end
            default:
            begin
                grid_reg <= grid_reg;
            end
        endcase
    end

endmodule

// File: rtl/core/mcgn_emit.sv
// Back end, second part: walk the 42 cells of a grid and present them as result beats.
module mcgn_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                grid_valid,
    input  mcgn_pkg::grid_t     grid,
    output logic                grid_take,
    input  logic                pop,
    output logic                empty,
    output logic [4:0]          cell_day,
    output logic [2:0]          cell_row,
    output logic [2:0]          cell_column,
    output logic                is_highlight,
    output logic [3:0]          shown_month,
    output logic [13:0]         shown_year,
    output logic                last_cell
);

    logic            active_reg;
    logic [5:0]      pos_reg;
    logic [2:0]      row_reg, col_reg;
    mcgn_pkg::grid_t cur_reg;

    logic            advance;
    logic [6:0]      diff;
    logic            in_month;

    assign last_cell = (pos_reg == 6'(mcgn_pkg::NUM_CELLS - 1));
    assign advance   = pop && active_reg;
    assign grid_take = grid_valid && (!active_reg || (advance && last_cell));
    assign empty     = !active_reg;

    assign diff     = {1'b0, pos_reg} - 7'(cur_reg.offset);
    assign in_month = (pos_reg >= 6'(cur_reg.offset)) && (diff[5:0] < 6'(cur_reg.ndays));

    assign cell_day     = in_month ? 5'(diff[4:0] + 5'd1) : 5'd0;
    assign cell_row     = row_reg;
    assign cell_column  = col_reg;
    assign is_highlight = (cell_day != 5'd0) && (cell_day == cur_reg.hl_day);
    assign shown_month  = cur_reg.month;
    assign shown_year   = cur_reg.year;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pos_reg    <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else if (grid_take)
        begin
            active_reg <= 1'b1;
            pos_reg    <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else if (advance)
        begin
            if (last_cell)
            begin
                active_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_reg + 6'd1;
                if (col_reg == 3'(mcgn_pkg::NUM_COLS - 1))
                begin
                    col_reg <= 3'd0;
                    row_reg <= row_reg + 3'd1;
                end
                else
                begin
                    col_reg <= col_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (grid_take)
        begin
            cur_reg <= grid;
        end
    end

endmodule

// File: rtl/core/month_calendar_grid_navigator.sv
// Top level of the month calendar grid navigator: configuration registers and the pipeline.
//
// Usage:
//   Events enter on a queue-style port: an event beat is taken at a rising edge with
//   push high and full low. Each beat carries operation, load_month and load_year.
//   Every accepted event that moves the view answers with 42 result beats, one per grid
//   cell, row by row and left to right; refused moves and unknown codes send nothing.
//   Result beats leave on a queue-style port: a cell is on the ports while empty is low
//   and is taken at an edge with pop high; last_cell marks the 42nd beat of a grid.
//   Configuration registers are written at once through cfg_write, cfg_index and
//   cfg_data; write them only while no grid is pending, which the block does not enforce.
// Timing:
//   The first cell shows once its event has passed the queue, the prep states P_IDLE to
//   P_FIN and the emitter's grid register. While pop stays high the emitter sends one
//   cell per cycle; the weekday and month length of the next grid are worked out while
//   the current one drains. A 4-entry event queue sits between the front and back ends,
//   so events are still taken while the receiver stalls; full rises only when it fills.
// Reset:
//   rst_n clears the queue and the pipeline, sets the view to January 2016 and loads
//   the register reset values (week start Sunday, highlight date 1 January 2016).
module month_calendar_grid_navigator #(
    parameter int YEAR_LIMIT = 9999
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  operation,
    input  logic [3:0]  load_month,
    input  logic [13:0] load_year,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  cell_day,
    output logic [2:0]  cell_row,
    output logic [2:0]  cell_column,
    output logic        is_highlight,
    output logic [3:0]  shown_month,
    output logic [13:0] shown_year,
    output logic        last_cell,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data
);

    mcgn_pkg::cfg_t  cfg_reg;
    mcgn_pkg::view_t q_wr_data, q_rd_data;
    mcgn_pkg::grid_t grid;
    logic            q_write, q_pop, q_empty, q_full;
    logic            grid_valid, grid_take;

    assign full = q_full;

    // Register bank: keep the low bits of the write data for each register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.col0_weekday    <= 3'd0;
            cfg_reg.highlight_day   <= 5'd1;
            cfg_reg.highlight_month <= 4'd1;
            cfg_reg.highlight_year  <= 14'd2016;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mcgn_pkg::CFG_COL0_WEEKDAY:    cfg_reg.col0_weekday    <= cfg_data[2:0];
                mcgn_pkg::CFG_HIGHLIGHT_DAY:   cfg_reg.highlight_day   <= cfg_data[4:0];
                mcgn_pkg::CFG_HIGHLIGHT_MONTH: cfg_reg.highlight_month <= cfg_data[3:0];
                mcgn_pkg::CFG_HIGHLIGHT_YEAR:  cfg_reg.highlight_year  <= cfg_data;
                default:                       cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Front end: classify the event and advance the view
    mcgn_front #(
        .YEAR_LIMIT (YEAR_LIMIT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .operation  (operation),
        .load_month (load_month),
        .load_year  (load_year),
        .cfg        (cfg_reg),
        .q_full     (q_full),
        .q_write    (q_write),
        .q_data     (q_wr_data)
    );

    // Decouple the two ends
    mcgn_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_write),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .q_empty (q_empty),
        .q_full  (q_full)
    );

    // Back end: Zeller weekday, month length, highlight
    mcgn_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_empty    (q_empty),
        .q_data     (q_rd_data),
        .q_pop      (q_pop),
        .grid_valid (grid_valid),
        .grid       (grid),
        .grid_take  (grid_take)
    );

    // Back end: one cell per beat
    mcgn_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .grid_valid   (grid_valid),
        .grid         (grid),
        .grid_take    (grid_take),
        .pop          (pop),
        .empty        (empty),
        .cell_day     (cell_day),
        .cell_row     (cell_row),
        .cell_column  (cell_column),
        .is_highlight (is_highlight),
        .shown_month  (shown_month),
        .shown_year   (shown_year),
        .last_cell    (last_cell)
    );

endmodule

// File: rtl/core/mcgn_checker.sv
// Port-level checker of the month calendar grid navigator, bound to the top level.
`include "assert_macros.svh"

module mcgn_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  logic        pop,
    input  logic [4:0]  cell_day,
    input  logic [2:0]  cell_row,
    input  logic [2:0]  cell_column,
    input  logic        is_highlight,
    input  logic [13:0] shown_year,
    input  logic        last_cell
);

    // The last beat of a grid sits in the bottom right corner
    `ASSERT_IMPLY(a_last_corner, clk, rst_n, !empty && last_cell, cell_row == 3'd5 && cell_column == 3'd6)

    // A grid never breaks off before its last beat
    `ASSERT_NEXT(a_run_continues, clk, rst_n, pop && !empty && !last_cell, !empty)

    // A new grid starts in the top left corner
    `ASSERT_NEXT(a_grid_start, clk, rst_n, pop && !empty && last_cell, empty || (cell_row == 3'd0 && cell_column == 3'd0))

    // Only a cell with a day can be highlighted
    `ASSERT_IMPLY(a_highlight_day, clk, rst_n, !empty && is_highlight, cell_day != 5'd0)

    // A stalled beat holds its cell
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, !empty && !pop, !empty && $stable(cell_day) && $stable(cell_row) && $stable(cell_column) && $stable(shown_year))

endmodule

bind month_calendar_grid_navigator mcgn_checker u_mcgn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .cell_day     (cell_day),
    .cell_row     (cell_row),
    .cell_column  (cell_column),
    .is_highlight (is_highlight),
    .shown_year   (shown_year),
    .last_cell    (last_cell)
);

// File: dv/month_calendar_grid_navigator_tb.sv
// Self-checking testbench for the month calendar grid navigator.
`timescale 1ns / 1ps

module month_calendar_grid_navigator_tb;

    localparam int CLK_PERIOD     = 4;
    localparam int YEAR_LIMIT     = 9999;
    localparam int RANDOM_EVENTS  = 290;  // counted events in the random part
    localparam int TAIL_EVENTS    = 40;   // last events run with no idling at all
    localparam int SETTLE_CYCLES  = 32;   // event queue plus pipeline depth, with margin
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 40;

    // Operation codes the block must ignore
    localparam logic [2:0] OP_RESERVED_6 = 3'd6;
    localparam logic [2:0] OP_RESERVED_7 = 3'd7;

    typedef struct packed {
        logic [4:0]  day;
        logic [2:0]  row;
        logic [2:0]  col;
        logic        hl;
        logic [3:0]  month;
        logic [13:0] year;
        logic        last;
    } grid_cell_t;

    typedef enum int {ROW_EVENT, ROW_TYPED, ROW_REG} row_kind_t;

    // One line of the directed plan: an event (maybe with a hand-typed outcome) or a
    // register write. Typed outcome: grid beats sent and the view after the event.
    typedef struct {
        row_kind_t            kind;
        logic [2:0]           op;
        logic [3:0]           arg_month;
        logic [13:0]          arg_year;
        mcgn_pkg::cfg_index_t reg_idx;
        logic [13:0]          reg_data;
        int                   want_beats;
        logic [3:0]           want_month;
        logic [13:0]          want_year;
    } plan_row_t;

    localparam int N_PLAN = 40;

    // Walk the view to both ends of the calendar, hit every refused case, then
    // exercise the highlight registers, including out-of-range values.
    plan_row_t directed_plan [N_PLAN] = '{
        '{ROW_TYPED, mcgn_pkg::OP_HOME, 4'd0, 14'd0,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 42, 4'd1, 14'd2016},
        '{ROW_TYPED, mcgn_pkg::OP_LOAD, 4'd1, 14'd1,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 42, 4'd1, 14'd1},
        '{ROW_TYPED, mcgn_pkg::OP_PREV_MONTH, 4'd0, 14'd0,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 0, 4'd1, 14'd1},
        '{ROW_TYPED, mcgn_pkg::OP_PREV_YEAR, 4'd0, 14'd0,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 0, 4'd1, 14'd1},
        '{ROW_TYPED, mcgn_pkg::OP_LOAD, 4'd12, 14'd9999,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 42, 4'd12, 14'd9999},
        '{ROW_TYPED, mcgn_pkg::OP_NEXT_MONTH, 4'd0, 14'd0,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 0, 4'd12, 14'd9999},
        '{ROW_TYPED, mcgn_pkg::OP_NEXT_YEAR, 4'd0, 14'd0,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 0, 4'd12, 14'd9999},
        '{ROW_TYPED, mcgn_pkg::OP_LOAD, 4'd0, 14'd2000,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 0, 4'd12, 14'd9999},
        '{ROW_TYPED, mcgn_pkg::OP_LOAD, 4'd13, 14'd2000,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 0, 4'd12, 14'd9999},
        '{ROW_TYPED, mcgn_pkg::OP_LOAD, 4'd15, 14'd16383,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 0, 4'd12, 14'd9999},
        '{ROW_TYPED, mcgn_pkg::OP_LOAD, 4'd5, 14'd0,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 0, 4'd12, 14'd9999},
        '{ROW_TYPED, mcgn_pkg::OP_LOAD, 4'd5, 14'd10000,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 0, 4'd12, 14'd9999},
        '{ROW_TYPED, OP_RESERVED_6, 4'd15, 14'd16383,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 0, 4'd12, 14'd9999},
        '{ROW_TYPED, OP_RESERVED_7, 4'd0, 14'd0,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 0, 4'd12, 14'd9999},
        '{ROW_EVENT, mcgn_pkg::OP_LOAD, 4'd2, 14'd2000,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 0, 4'd0, 14'd0},
        '{ROW_EVENT, mcgn_pkg::OP_LOAD, 4'd2, 14'd1900,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 0, 4'd0, 14'd0},
        '{ROW_EVENT, mcgn_pkg::OP_LOAD, 4'd4, 14'd2021,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 0, 4'd0, 14'd0},
        '{ROW_EVENT, mcgn_pkg::OP_PREV_YEAR, 4'd0, 14'd0,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 0, 4'd0, 14'd0},
        '{ROW_REG, mcgn_pkg::OP_LOAD, 4'd0, 14'd0,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd6, 0, 4'd0, 14'd0},
        '{ROW_REG, mcgn_pkg::OP_LOAD, 4'd0, 14'd0,
          mcgn_pkg::CFG_HIGHLIGHT_DAY, 14'd31, 0, 4'd0, 14'd0},
        '{ROW_REG, mcgn_pkg::OP_LOAD, 4'd0, 14'd0,
          mcgn_pkg::CFG_HIGHLIGHT_MONTH, 14'd12, 0, 4'd0, 14'd0},
        '{ROW_REG, mcgn_pkg::OP_LOAD, 4'd0, 14'd0,
          mcgn_pkg::CFG_HIGHLIGHT_YEAR, 14'd9999, 0, 4'd0, 14'd0},
        '{ROW_EVENT, mcgn_pkg::OP_HOME, 4'd0, 14'd0,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 0, 4'd0, 14'd0},
        '{ROW_EVENT, mcgn_pkg::OP_PREV_MONTH, 4'd0, 14'd0,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 0, 4'd0, 14'd0},
        '{ROW_REG, mcgn_pkg::OP_LOAD, 4'd0, 14'd0,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd7, 0, 4'd0, 14'd0},
        '{ROW_REG, mcgn_pkg::OP_LOAD, 4'd0, 14'd0,
          mcgn_pkg::CFG_HIGHLIGHT_DAY, 14'd0, 0, 4'd0, 14'd0},
        '{ROW_EVENT, mcgn_pkg::OP_HOME, 4'd0, 14'd0,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 0, 4'd0, 14'd0},
        '{ROW_REG, mcgn_pkg::OP_LOAD, 4'd0, 14'd0,
          mcgn_pkg::CFG_HIGHLIGHT_DAY, 14'd30, 0, 4'd0, 14'd0},
        '{ROW_REG, mcgn_pkg::OP_LOAD, 4'd0, 14'd0,
          mcgn_pkg::CFG_HIGHLIGHT_MONTH, 14'd2, 0, 4'd0, 14'd0},
        '{ROW_REG, mcgn_pkg::OP_LOAD, 4'd0, 14'd0,
          mcgn_pkg::CFG_HIGHLIGHT_YEAR, 14'd2000, 0, 4'd0, 14'd0},
        '{ROW_EVENT, mcgn_pkg::OP_HOME, 4'd0, 14'd0,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 0, 4'd0, 14'd0},
        '{ROW_REG, mcgn_pkg::OP_LOAD, 4'd0, 14'd0,
          mcgn_pkg::CFG_HIGHLIGHT_MONTH, 14'd13, 0, 4'd0, 14'd0},
        '{ROW_TYPED, mcgn_pkg::OP_HOME, 4'd0, 14'd0,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 0, 4'd2, 14'd2000},
        '{ROW_REG, mcgn_pkg::OP_LOAD, 4'd0, 14'd0,
          mcgn_pkg::CFG_HIGHLIGHT_MONTH, 14'd0, 0, 4'd0, 14'd0},
        '{ROW_TYPED, mcgn_pkg::OP_HOME, 4'd0, 14'd0,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 0, 4'd2, 14'd2000},
        '{ROW_REG, mcgn_pkg::OP_LOAD, 4'd0, 14'd0,
          mcgn_pkg::CFG_HIGHLIGHT_MONTH, 14'd3, 0, 4'd0, 14'd0},
        '{ROW_REG, mcgn_pkg::OP_LOAD, 4'd0, 14'd0,
          mcgn_pkg::CFG_HIGHLIGHT_YEAR, 14'd16383, 0, 4'd0, 14'd0},
        '{ROW_TYPED, mcgn_pkg::OP_HOME, 4'd0, 14'd0,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 0, 4'd2, 14'd2000},
        '{ROW_REG, mcgn_pkg::OP_LOAD, 4'd0, 14'd0,
          mcgn_pkg::CFG_HIGHLIGHT_YEAR, 14'd0, 0, 4'd0, 14'd0},
        '{ROW_TYPED, mcgn_pkg::OP_HOME, 4'd0, 14'd0,
          mcgn_pkg::CFG_COL0_WEEKDAY, 14'd0, 0, 4'd2, 14'd2000}
    };

    // Block ports; every input starts at a known value
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  operation = mcgn_pkg::OP_LOAD;
    logic [3:0]  load_month = 4'd1;
    logic [13:0] load_year = 14'd2016;
    logic        empty;
    logic        pop = 1'b0;
    logic [4:0]  cell_day;
    logic [2:0]  cell_row;
    logic [2:0]  cell_column;
    logic        is_highlight;
    logic [3:0]  shown_month;
    logic [13:0] shown_year;
    logic        last_cell;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = mcgn_pkg::CFG_COL0_WEEKDAY;
    logic [13:0] cfg_data = 14'd0;

    // Predictor copy of the view and of the registers, at their reset values
    int cal_month = 1;
    int cal_year = 2016;
    int wk_start = 0;
    int hl_day = 1;
    int hl_month = 1;
    int hl_year = 2016;

    grid_cell_t cells_due[$];   // cells still owed by the block, oldest first
    int  errors = 0;
    int  quiet_cycles = 0;
    bit  steady_tail = 1'b0;    // set for the last stretch: no idling on either side

    month_calendar_grid_navigator #(
        .YEAR_LIMIT(YEAR_LIMIT)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .load_month  (load_month),
        .load_year   (load_year),
        .empty       (empty),
        .pop         (pop),
        .cell_day    (cell_day),
        .cell_row    (cell_row),
        .cell_column (cell_column),
        .is_highlight(is_highlight),
        .shown_month (shown_month),
        .shown_year  (shown_year),
        .last_cell   (last_cell),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Apply one navigation event to the predicted view. On success, queue the 42 cells
    // of the new month and return how many beats the block owes; refused events and
    // unknown codes leave the view alone and owe nothing.
    function automatic int advance_view(input logic [2:0] op, input logic [3:0] lm,
                                        input logic [13:0] ly);
        int nm, ny, idx, ndays, offset, day, zm, zy, c, k, first;
        bit leap, hl_view;
        grid_cell_t slot;
        nm = cal_month;
        ny = cal_year;
        case (op)
            mcgn_pkg::OP_LOAD:
            begin
                if (lm < 1 || lm > 12 || ly < 1 || ly > YEAR_LIMIT)
                begin
                    return 0;
                end
                nm = int'(lm);
                ny = int'(ly);
            end
            mcgn_pkg::OP_PREV_MONTH, mcgn_pkg::OP_NEXT_MONTH:
            begin
                // Step on a flat month count so the year boundary falls out naturally
                idx = ny * 12 + nm - 1;
                if (op == mcgn_pkg::OP_PREV_MONTH)
                begin
                    if (idx <= 12)
                    begin
                        return 0;
                    end
                    idx--;
                end
                else
                begin
                    if (idx + 1 >= (YEAR_LIMIT + 1) * 12)
                    begin
                        return 0;
                    end
                    idx++;
                end
                ny = idx / 12;
                nm = idx % 12 + 1;
            end
            mcgn_pkg::OP_PREV_YEAR:
            begin
                if (ny <= 1)
                begin
                    return 0;
                end
                ny--;
            end
            mcgn_pkg::OP_NEXT_YEAR:
            begin
                if (ny >= YEAR_LIMIT)
                begin
                    return 0;
                end
                ny++;
            end
            mcgn_pkg::OP_HOME:
            begin
                if (hl_month < 1 || hl_month > 12 || hl_year < 1 || hl_year > YEAR_LIMIT)
                begin
                    return 0;
                end
                nm = hl_month;
                ny = hl_year;
            end
            default:
            begin
                return 0;
            end
        endcase

        cal_month = nm;
        cal_year = ny;

        leap = ((ny % 4 == 0) && (ny % 100 != 0)) || (ny % 400 == 0);
        case (nm)
            2:              ndays = leap ? 29 : 28;
            4, 6, 9, 11:    ndays = 30;
            default:        ndays = 31;
        endcase

        // Zeller: January and February count as months 13 and 14 of the year before
        zm = nm;
        zy = ny;
        if (zm < 3)
        begin
            zm += 12;
            zy -= 1;
        end
        c = zy / 100;
        k = zy % 100;
        first = ((13 * (zm + 1)) / 5 + c / 4 + 5 * c + k + k / 4) % 7;
        offset = (first + 7 - wk_start % 7) % 7;
        hl_view = (nm == hl_month) && (ny == hl_year);

        for (int pos = 0; pos < mcgn_pkg::NUM_CELLS; pos++)
        begin
            day = (pos >= offset && pos - offset < ndays) ? pos - offset + 1 : 0;
            slot.day   = 5'(day);
            slot.row   = 3'(pos / mcgn_pkg::NUM_COLS);
            slot.col   = 3'(pos % mcgn_pkg::NUM_COLS);
            slot.hl    = (day != 0) && hl_view && (day == hl_day);
            slot.month = 4'(nm);
            slot.year  = 14'(ny);
            slot.last  = (pos == mcgn_pkg::NUM_CELLS - 1);
            cells_due.push_back(slot);
        end
        return mcgn_pkg::NUM_CELLS;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
            begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, what, want, got);
            end
        end
    endtask

    // Offer one event beat after an optional idle burst; hold it until taken, then
    // predict its grid. Push stays high on return so back-to-back beats need no gap.
    task automatic send_event(input logic [2:0] op, input logic [3:0] lm,
                              input logic [13:0] ly, input int gap_pct, output int beats);
        if (!steady_tail && $urandom_range(0, 99) < gap_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        push       <= 1'b1;
        operation  <= op;
        load_month <= lm;
        load_year  <= ly;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        beats = advance_view(op, lm, ly);
    endtask

    // Drop push, drain every owed cell, then let the block settle before the
    // registers change.
    task automatic wait_idle();
        push <= 1'b0;
        while (cells_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input mcgn_pkg::cfg_index_t idx, input logic [13:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            mcgn_pkg::CFG_COL0_WEEKDAY:    wk_start = int'(data[2:0]);
            mcgn_pkg::CFG_HIGHLIGHT_DAY:   hl_day   = int'(data[4:0]);
            mcgn_pkg::CFG_HIGHLIGHT_MONTH: hl_month = int'(data[3:0]);
            mcgn_pkg::CFG_HIGHLIGHT_YEAR:  hl_year  = int'(data);
            default:                       ;
        endcase
        @(posedge clk);
    endtask

    // Receiver: pop in random stretches with random idle bursts between them
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            if (!steady_tail && $urandom_range(0, 3) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Result checker: every beat taken must match the oldest owed cell
    always @(posedge clk)
    begin
        grid_cell_t want;
        if (rst_n && pop && !empty)
        begin
            if (cells_due.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("%0t ns: unexpected cell beat, expected none, %s %0d %0d/%0d",
                             $time, "actual day", cell_day, shown_month, shown_year);
                end
            end
            else
            begin
                want = cells_due.pop_front();
                check_field("cell_day",     want.day,   cell_day);
                check_field("cell_row",     want.row,   cell_row);
                check_field("cell_column",  want.col,   cell_column);
                check_field("is_highlight", want.hl,    is_highlight);
                check_field("shown_month",  want.month, shown_month);
                check_field("shown_year",   want.year,  shown_year);
                check_field("last_cell",    want.last,  last_cell);
            end
        end
    end

    // Watchdog: end the run if no beat or register write happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || cfg_write)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        plan_row_t   row;
        int          beats;
        int          counted;
        int          gap_pct;
        int          pick;
        int          phase_len;
        bit          extremes;
        logic [2:0]  op;
        logic [3:0]  lm;
        logic [13:0] ly;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: typed rows also cross-check the predictor by hand
        for (int i = 0; i < N_PLAN; i++)
        begin
            row = directed_plan[i];
            if (row.kind == ROW_REG)
            begin
                wait_idle();
                write_reg(row.reg_idx, row.reg_data);
            end
            else
            begin
                send_event(row.op, row.arg_month, row.arg_year, 25, beats);
                if (row.kind == ROW_TYPED)
                begin
                    check_field("grid beats", row.want_beats, beats);
                    check_field("view month", row.want_month, cal_month);
                    check_field("view year",  row.want_year,  cal_year);
                end
            end
        end

        // Random part: phases of events, each behind a fresh register setting
        counted = 0;
        while (counted < RANDOM_EVENTS)
        begin
            wait_idle();
            extremes = ($urandom_range(0, 3) == 0);
            if (extremes || $urandom_range(0, 1))
            begin
                write_reg(mcgn_pkg::CFG_COL0_WEEKDAY,
                          14'(extremes ? (($urandom_range(0, 1)) ? 6 : 7)
                                       : $urandom_range(0, 7)));
            end
            if (extremes || $urandom_range(0, 1))
            begin
                write_reg(mcgn_pkg::CFG_HIGHLIGHT_DAY,
                          14'(extremes ? (($urandom_range(0, 1)) ? 1 : 31)
                                       : $urandom_range(0, 31)));
            end
            if (extremes || $urandom_range(0, 1))
            begin
                if (extremes)
                begin
                    write_reg(mcgn_pkg::CFG_HIGHLIGHT_MONTH,
                              14'(($urandom_range(0, 1)) ? 1 : 12));
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    write_reg(mcgn_pkg::CFG_HIGHLIGHT_MONTH,
                              14'(($urandom_range(0, 1)) ? 0 : $urandom_range(13, 15)));
                end
                else
                begin
                    write_reg(mcgn_pkg::CFG_HIGHLIGHT_MONTH, 14'($urandom_range(1, 12)));
                end
            end
            if (extremes || $urandom_range(0, 1))
            begin
                if (extremes)
                begin
                    write_reg(mcgn_pkg::CFG_HIGHLIGHT_YEAR,
                              14'(($urandom_range(0, 1)) ? 1 : YEAR_LIMIT));
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    write_reg(mcgn_pkg::CFG_HIGHLIGHT_YEAR,
                              14'(($urandom_range(0, 1)) ? 0
                                  : $urandom_range(YEAR_LIMIT + 1, 16383)));
                end
                else
                begin
                    write_reg(mcgn_pkg::CFG_HIGHLIGHT_YEAR,
                              14'($urandom_range(1, YEAR_LIMIT)));
                end
            end

            // Some phases run with no sender gaps at all; the tail runs as one phase
            gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
            phase_len = $urandom_range(8, 40);
            for (int n = 0; (n < phase_len || steady_tail) && counted < RANDOM_EVENTS; n++)
            begin
                if (counted >= RANDOM_EVENTS - TAIL_EVENTS)
                begin
                    steady_tail = 1'b1;
                end
                // Valid loads, with years pulled to the calendar ends now and then
                lm = 4'($urandom_range(1, 12));
                if ($urandom_range(0, 7) == 0)
                begin
                    ly = 14'(($urandom_range(0, 1)) ? $urandom_range(1, 2)
                             : $urandom_range(YEAR_LIMIT - 1, YEAR_LIMIT));
                    lm = ($urandom_range(0, 1)) ? 4'd1 : 4'd12;
                end
                else
                begin
                    ly = 14'($urandom_range(1, YEAR_LIMIT));
                end
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    op = mcgn_pkg::OP_LOAD;
                end
                else if (pick < 50)
                begin
                    op = mcgn_pkg::OP_PREV_MONTH;
                end
                else if (pick < 65)
                begin
                    op = mcgn_pkg::OP_NEXT_MONTH;
                end
                else if (pick < 73)
                begin
                    op = mcgn_pkg::OP_PREV_YEAR;
                end
                else if (pick < 81)
                begin
                    op = mcgn_pkg::OP_NEXT_YEAR;
                end
                else if (pick < 90)
                begin
                    op = mcgn_pkg::OP_HOME;
                end
                else if (pick < 96)
                begin
                    // Broken load: month or year out of range
                    op = mcgn_pkg::OP_LOAD;
                    if ($urandom_range(0, 1))
                    begin
                        lm = 4'(($urandom_range(0, 1)) ? 0 : $urandom_range(13, 15));
                    end
                    else
                    begin
                        ly = 14'(($urandom_range(0, 1)) ? 0
                                 : $urandom_range(YEAR_LIMIT + 1, 16383));
                    end
                end
                else
                begin
                    op = ($urandom_range(0, 1)) ? OP_RESERVED_6 : OP_RESERVED_7;
                    lm = 4'($urandom_range(0, 15));
                    ly = 14'($urandom_range(0, 16383));
                end
                send_event(op, lm, ly, gap_pct, beats);
                if (op != OP_RESERVED_6 && op != OP_RESERVED_7)
                begin
                    counted++;
                end
                // Now and then hold the sender until every owed cell is out
                if (!steady_tail && $urandom_range(0, 24) == 0)
                begin
                    push <= 1'b0;
                    do
                    begin
                        @(posedge clk);
                    end
                    while (cells_due.size() != 0);
                end
            end
        end

        wait_idle();
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
